### design/b64e_pkg.sv
package b64e_pkg;

    // default depth of the group queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // ascii '=' used as padding
    localparam logic [6:0] PAD_CHAR = 7'd61;

    // number of trailing pad characters in a group
    localparam logic [1:0] PAD_NONE = 2'd0;
    localparam logic [1:0] PAD_ONE  = 2'd1;
    localparam logic [1:0] PAD_TWO  = 2'd2;

    // one 24-bit group ready for encoding
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  pads;
        logic        last;
    } t_group;

    // standard alphabet lookup, six bits to ascii
    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] wide;
        wide = {1'b0, v};
        if (v < 6'd26) begin
            sextet_char = wide + 7'd65;
        end else if (v < 6'd52) begin
            sextet_char = wide + 7'd71;
        end else if (v < 6'd62) begin
            sextet_char = wide - 7'd4;
        end else if (v == 6'd62) begin
            sextet_char = 7'd43;
        end else begin
            sextet_char = 7'd47;
        end
    endfunction

endpackage

### design/b64e_front.sv
module b64e_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_final_byte,
    input  logic                 i_full,
    output logic                 o_stall,
    output logic                 o_push,
    output b64e_pkg::t_group     o_group
);

    localparam logic [1:0] FILL_ZERO = 2'd0;
    localparam logic [1:0] FILL_ONE  = 2'd1;
    localparam logic [1:0] FILL_TWO  = 2'd2;

    logic [15:0] r_pending, n_pending;
    logic [1:0]  r_fill, n_fill;
    logic        accept;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        n_pending     = r_pending;
        n_fill        = r_fill;
        o_push        = 1'b0;
        o_group.word  = {r_pending, i_data_byte};
        o_group.pads  = b64e_pkg::PAD_NONE;
        o_group.last  = i_final_byte;
        case (r_fill)
            FILL_TWO: begin
                if (accept) begin
                    o_push = 1'b1;
                    n_fill = FILL_ZERO;
                end
            end
            FILL_ONE: begin
                o_group.word = {r_pending[15:8], i_data_byte, 8'h00};
                o_group.pads = b64e_pkg::PAD_ONE;
                if (accept) begin
                    if (i_final_byte) begin
                        o_push = 1'b1;
                        n_fill = FILL_ZERO;
                    end else begin
                        n_pending = {r_pending[15:8], i_data_byte};
                        n_fill    = FILL_TWO;
                    end
                end
            end
            default: begin
                // empty group; an impossible fill of three also lands here
                o_group.word = {i_data_byte, 16'h0000};
                o_group.pads = b64e_pkg::PAD_TWO;
                if (accept) begin
                    if (i_final_byte) begin
                        o_push = 1'b1;
                        n_fill = FILL_ZERO;
                    end else begin
                        n_pending = {i_data_byte, 8'h00};
                        n_fill    = FILL_ONE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= FILL_ZERO;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pending <= n_pending;
    end

endmodule

### design/b64e_queue.sv
module b64e_queue #(
    parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  b64e_pkg::t_group     i_group,
    input  logic                 i_pop,
    output logic                 o_valid,
    output logic                 o_full,
    output b64e_pkg::t_group     o_group
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64e_pkg::t_group r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_group = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_group;
        end
    end

endmodule

### design/b64e_back.sv
module b64e_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  b64e_pkg::t_group     i_q_group,
    output logic                 o_pop,
    output logic                 o_out_valid,
    output logic [6:0]           o_out_char,
    output logic                 o_last_char,
    input  logic                 i_out_stall
);

    logic             r_busy, n_busy;
    logic [1:0]       r_idx, n_idx;
    b64e_pkg::t_group r_grp;
    logic             r_out_valid, n_out_valid;
    logic [6:0]       r_out_char;
    logic             r_out_last;
    logic             out_free, load, is_pad;
    logic [5:0]       sextet;
    logic [6:0]       ch;

    assign out_free = !r_out_valid || !i_out_stall;
    assign load     = out_free && r_busy;
    assign o_pop    = i_q_valid && (!r_busy || (load && r_idx == 2'd3));

    always_comb begin
        case (r_idx)
            2'd0:    sextet = r_grp.word[23:18];
            2'd1:    sextet = r_grp.word[17:12];
            2'd2:    sextet = r_grp.word[11:6];
            default: sextet = r_grp.word[5:0];
        endcase
        is_pad = ((r_idx == 2'd3) && (r_grp.pads != b64e_pkg::PAD_NONE)) ||
                 ((r_idx == 2'd2) && (r_grp.pads == b64e_pkg::PAD_TWO));
        ch = is_pad ? b64e_pkg::PAD_CHAR : b64e_pkg::sextet_char(sextet);
    end

    always_comb begin
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
            n_idx       = r_idx + 1'b1;
            if (r_idx == 2'd3) begin
                n_busy = 1'b0;
            end
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_grp <= i_q_group;
        end
        if (load) begin
            r_out_char <= ch;
            r_out_last <= (r_idx == 2'd3) && r_grp.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_out_last;

endmodule

### design/base64_encoder_core.sv
// base64 encoder, standard alphabet with '=' padding. message bytes come in
// one beat each, the final one flagged; every group of three bytes, or the
// short group closed by the final byte, leaves as four ascii characters, one
// beat each, the last character of the message flagged. the front takes one
// byte per cycle while the group queue has room; the output register sends
// one character per cycle while the output is not stalled, so on a long
// message the single-character output sets the pace. a closed group goes
// from the queue to the back's group register, then to the output register.
module base64_encoder_core #(
    parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    // character channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_out_char,
    output logic       o_last_char
);

    // groups handed from front to back
    logic             q_push, q_pop, q_valid, q_full;
    b64e_pkg::t_group f_group;
    b64e_pkg::t_group q_group;

    // front: gathers bytes into a group, builds padding info
    b64e_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .i_full       (q_full),
        .o_stall      (o_in_stall),
        .o_push       (q_push),
        .o_group      (f_group)
    );

    // short queue so front and back stall on their own
    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_group (f_group),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_group (q_group)
    );

    // back: four characters per group through the output register
    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_group   (q_group),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char),
        .i_out_stall (i_out_stall)
    );

    // a group is never pushed into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("group pushed into full queue");

    // the back never pops an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    // a final byte always leaves a group waiting in the queue
    a_final_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_final_byte) |=> q_valid)
        else $error("final byte did not reach the queue");

endmodule

### tb/sv/base64_encoder_core_tb.sv
`timescale 1ns / 1ps

module base64_encoder_core_tb;

    // standard alphabet, character 0 in the top byte
    localparam logic [64*8-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    localparam int RANDOM_BYTES  = 260;
    localparam int HOLD_CYCLES   = 150;
    localparam int DRAIN_CYCLES  = 20;

    // one byte beat waiting to be driven, with the idle gap that follows it
    typedef struct {
        logic [7:0] data;
        logic       fin;
        int         gap;
    } t_byte_beat;

    // one character beat the encoder should produce
    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } t_char_beat;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [7:0] i_data_byte  = 8'h00;
    logic       i_final_byte = 1'b0;
    logic       i_out_stall  = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [6:0] o_out_char;
    logic       o_last_char;

    t_byte_beat pending_beats[$];
    t_char_beat expected_chars[$];

    // predictor state: bytes held from the open group
    logic [15:0] held_bytes = 16'h0000;
    logic [1:0]  held_count = 2'd0;

    int error_count = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    int hold_left   = 0;
    int chars_seen  = 0;
    bit quiet_out   = 1'b0;

    base64_encoder_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_char   (o_out_char),
        .o_last_char  (o_last_char)
    );

    always #10 i_clk = ~i_clk;

    // six bits to ascii through the alphabet string
    function automatic logic [6:0] sextet_to_ascii(input logic [5:0] v);
        logic [7:0] ch;
        ch = ALPHABET[(63 - v) * 8 +: 8];
        return ch[6:0];
    endfunction

    // predictor: fold one accepted byte into the open group, and when the
    // group closes (third byte or final byte) queue its four characters
    task automatic encode_byte(input logic [7:0] b, input logic fin);
        logic [23:0] word;
        int          pads;
        bit          emit;
        int          k;
        t_char_beat  beat;
        word = 24'h0;
        pads = 0;
        emit = 1'b0;
        if (held_count == 2'd2) begin
            // full group, final flag passes straight through
            word = {held_bytes, b};
            emit = 1'b1;
        end else if (fin) begin
            // short group: zero fill, then pad one or two characters
            if (held_count == 2'd0) begin
                word = {b, 16'h0000};
                pads = 2;
            end else begin
                word = {held_bytes[15:8], b, 8'h00};
                pads = 1;
            end
            emit = 1'b1;
        end else if (held_count == 2'd0) begin
            held_bytes = {b, 8'h00};
            held_count = 2'd1;
        end else begin
            held_bytes[7:0] = b;
            held_count = 2'd2;
        end
        if (emit) begin
            for (k = 0; k < 4; k++) begin
                beat.code = (k >= 4 - pads) ? b64e_pkg::PAD_CHAR
                                            : sextet_to_ascii(word[18 - 6 * k +: 6]);
                beat.last = (k == 3) ? fin : 1'b0;
                expected_chars.push_back(beat);
            end
            held_bytes = 16'h0000;
            held_count = 2'd0;
        end
    endtask

    // compare one received character beat with the oldest expectation
    task automatic check_char(input logic [6:0] code, input logic last);
        t_char_beat exp_beat;
        if (expected_chars.size() == 0) begin
            $display("%0t: unexpected char: expected none, actual char %0d last %0b",
                     $time, code, last);
            error_count++;
        end else begin
            exp_beat = expected_chars.pop_front();
            if (code !== exp_beat.code) begin
                $display("%0t: out_char mismatch: expected %0d, actual %0d",
                         $time, exp_beat.code, code);
                error_count++;
            end
            if (last !== exp_beat.last) begin
                $display("%0t: last_char mismatch: expected %0b, actual %0b",
                         $time, exp_beat.last, last);
                error_count++;
            end
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic fin, input int gap);
        t_byte_beat beat;
        beat.data = b;
        beat.fin  = fin;
        beat.gap  = gap;
        pending_beats.push_back(beat);
    endtask

    // byte driver: a beat is taken when valid is high and stall is low; a new
    // beat is only presented once the slot is free, so a stalled beat holds
    always @(posedge i_clk) begin
        t_byte_beat nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                encode_byte(i_data_byte, i_final_byte);
            end
            // slot free: either nothing offered or the offered beat just went
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    nxt = pending_beats.pop_front();
                    i_in_valid   <= 1'b1;
                    i_data_byte  <= nxt.data;
                    i_final_byte <= nxt.fin;
                    gap_left = nxt.gap;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // character monitor and stall generator
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                check_char(o_out_char, o_last_char);
                chars_seen++;
                // long hold-offs so the group queue fills and the byte side stalls
                if (chars_seen == 60 || chars_seen == 300) begin
                    hold_left = HOLD_CYCLES;
                end
                // alternate between stretches of random stalls and none at all
                if (chars_seen % 80 == 0) begin
                    quiet_out = !quiet_out;
                end
                stall_left = quiet_out ? 0 : $urandom_range(0, 15);
            end else begin
                if (stall_left > 0) begin
                    stall_left--;
                end
                if (hold_left > 0) begin
                    hold_left--;
                end
            end
            i_out_stall <= (stall_left != 0) || (hold_left != 0);
        end
    end

    // stimulus and end of run
    initial begin
        int  total;
        int  len;
        int  n;
        bit  burst;

        // single byte messages at both extremes, two pads each
        queue_byte(8'h00, 1'b1, 0);
        queue_byte(8'hFF, 1'b1, 3);
        // two byte message, one pad
        queue_byte(8'hFF, 1'b0, 0);
        queue_byte(8'h00, 1'b1, 2);
        // all zero group
        queue_byte(8'h00, 1'b0, 0);
        queue_byte(8'h00, 1'b0, 0);
        queue_byte(8'h00, 1'b1, 0);
        // group that maps to '+' and '/'
        queue_byte(8'hFB, 1'b0, 1);
        queue_byte(8'hFF, 1'b0, 0);
        queue_byte(8'hBF, 1'b1, 5);
        // full group then a one byte tail
        queue_byte(8'h4D, 1'b0, 0);
        queue_byte(8'h61, 1'b0, 0);
        queue_byte(8'h6E, 1'b0, 0);
        queue_byte(8'hFF, 1'b1, 0);
        // full group then a two byte tail
        queue_byte(8'h12, 1'b0, 0);
        queue_byte(8'h34, 1'b0, 4);
        queue_byte(8'h56, 1'b0, 0);
        queue_byte(8'h78, 1'b0, 0);
        queue_byte(8'h9A, 1'b1, 0);

        // random messages, mostly short, a few long ones
        total = 0;
        while (total < RANDOM_BYTES) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                              : $urandom_range(1, 12);
            burst = ($urandom_range(0, 3) == 0);
            for (n = 0; n < len; n++) begin
                queue_byte(8'($urandom_range(0, 255)), n == len - 1,
                           burst ? 0 : $urandom_range(0, 15));
            end
            total += len;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every beat taken and every character back
        while (pending_beats.size() != 0 || i_in_valid || expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
        // drain time to catch any stray character
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
design/b64e_pkg.sv
design/b64e_front.sv
design/b64e_queue.sv
design/b64e_back.sv
design/base64_encoder_core.sv
tb/sv/base64_encoder_core_tb.sv
